// ===== rtl/core/z85dw_pkg.sv =====
// Shared types, constants and the Z85 reverse lookup for the double word decoder.
// No dependencies; every other file of the block depends on this package.
package z85dw_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 7;
    localparam int HALF_W  = 32;
    localparam int WORD_W  = 64;
    localparam int LEN_W   = 16;
    localparam int POS_W   = 4;

    localparam logic [HALF_W-1:0]  Z85_BASE    = 32'd85;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 16'd400;
    localparam logic [POS_W-1:0]   POS_FIRST   = 4'd0;
    localparam logic [POS_W-1:0]   POS_LOW_END = 4'd4;
    localparam logic [POS_W-1:0]   POS_HIGH    = 4'd5;
    localparam logic [POS_W-1:0]   POS_FINAL   = 4'd9;

    // Digit value for bytes 0x00..0x7F; bytes outside the alphabet map to zero.
    localparam logic [DIGIT_W-1:0] Z85_DIGIT [0:127] = '{
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h44, 7'h00, 7'h54, 7'h53, 7'h52, 7'h48, 7'h00,
        7'h4b, 7'h4c, 7'h46, 7'h41, 7'h00, 7'h3f, 7'h3e, 7'h45,
        7'h00, 7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07,
        7'h08, 7'h09, 7'h40, 7'h00, 7'h49, 7'h42, 7'h4a, 7'h47,
        7'h51, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2a,
        7'h2b, 7'h2c, 7'h2d, 7'h2e, 7'h2f, 7'h30, 7'h31, 7'h32,
        7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3a,
        7'h3b, 7'h3c, 7'h3d, 7'h4d, 7'h00, 7'h4e, 7'h43, 7'h00,
        7'h00, 7'h0a, 7'h0b, 7'h0c, 7'h0d, 7'h0e, 7'h0f, 7'h10,
        7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18,
        7'h19, 7'h1a, 7'h1b, 7'h1c, 7'h1d, 7'h1e, 7'h1f, 7'h20,
        7'h21, 7'h22, 7'h23, 7'h4f, 7'h00, 7'h50, 7'h00, 7'h00
    };

    // Registered digit handed from the input stage to the accumulator stage.
    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] digit;
    } digit_stage_t;

    function automatic logic [DIGIT_W-1:0] z85_digit(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = c[CHAR_W-1] ? '0 : Z85_DIGIT[c[CHAR_W-2:0]];
        return d;
    endfunction

endpackage

// ===== rtl/core/z85dw_if.sv =====
// Channel interfaces of the Z85 double word decoder: characters, words and configuration.
// Depends on z85dw_pkg for the field widths.
interface z85dw_char_if;
    logic                         valid;
    logic                         ready;
    logic [z85dw_pkg::CHAR_W-1:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface z85dw_word_if;
    logic                         valid;
    logic                         ready;
    logic [z85dw_pkg::WORD_W-1:0] decoded_word;
    logic                         last_in_vector;

    modport source (output valid, output decoded_word, output last_in_vector, input ready);
    modport sink   (input valid, input decoded_word, input last_in_vector, output ready);
endinterface

interface z85dw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [z85dw_pkg::LEN_W-1:0] vector_length;

    modport source (output valid, output vector_length, input ready);
    modport sink   (input valid, input vector_length, output ready);
endinterface

// ===== rtl/core/z85dw_in_stage.sv =====
// Input register of the Z85 decoder: looks up the digit of each character and holds it.
// Depends on z85dw_pkg and the character channel interface.
module z85dw_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    z85dw_char_if.sink              chars,
    input  logic                    take,
    output z85dw_pkg::digit_stage_t stage
);
    import z85dw_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [DIGIT_W-1:0] digit_reg;
    logic               load;

    // The register may refill in the same cycle that the next stage takes its item.
    assign chars.ready = !valid_reg || take;
    assign load        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digit_reg <= z85_digit(chars.in_char);
        end
    end

    assign stage.valid = valid_reg;
    assign stage.digit = digit_reg;

endmodule

// ===== rtl/core/z85dw_acc.sv =====
// Accumulator stage of the Z85 decoder: folds digits into words and holds the result item.
// Depends on z85dw_pkg and the word and configuration channel interfaces.
module z85dw_acc (
    input  logic                    clk,
    input  logic                    rst_n,
    input  z85dw_pkg::digit_stage_t stage,
    output logic                    take,
    z85dw_word_if.source            words,
    z85dw_cfg_if.sink               cfg
);
    import z85dw_pkg::*;

    logic [HALF_W-1:0] acc_reg;
    logic [HALF_W-1:0] acc_next;
    logic [POS_W-1:0]  pos_reg;
    logic [HALF_W-1:0] low_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_inc;
    logic [LEN_W-1:0]  len_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_last_reg;
    logic              emit;
    logic              is_last;
    logic              restart;

    assign cfg.ready = 1'b1;

    // Positions past nine cannot occur from reset; they are treated as the final one.
    assign emit    = pos_reg >= POS_FINAL;
    assign restart = (pos_reg == POS_FIRST) || (pos_reg == POS_HIGH);
    assign take    = stage.valid && (!emit || !out_valid_reg || words.ready);

    assign acc_next  = (restart ? '0 : acc_reg * Z85_BASE)
                     + {{(HALF_W-DIGIT_W){1'b0}}, stage.digit};
    assign count_inc = count_reg + 1'b1;
    assign is_last   = count_inc == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pos_reg       <= '0;
            low_reg       <= '0;
            count_reg     <= '0;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                len_reg <= cfg.vector_length;
            end
            if (take)
            begin
                acc_reg <= acc_next;
                pos_reg <= emit ? POS_FIRST : pos_reg + 1'b1;
                if (pos_reg == POS_LOW_END)
                begin
                    low_reg <= acc_next;
                end
                if (emit)
                begin
                    count_reg <= is_last ? '0 : count_inc;
                end
            end
            if (take && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (words.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_word_reg <= {acc_next, low_reg};
            out_last_reg <= is_last;
        end
    end

    assign words.valid          = out_valid_reg;
    assign words.decoded_word   = out_word_reg;
    assign words.last_in_vector = out_last_reg;

endmodule

// ===== rtl/core/z85_double_word_decoder.sv =====
// Top level of the Z85 double word decoder: input register plus accumulator stage.
// Depends on z85dw_pkg, the channel interfaces, z85dw_in_stage and z85dw_acc.
//
// Usage: the chars channel takes one Z85 character byte per item. Every ten
// characters form one 64-bit word: characters one to five give the low half,
// six to ten the high half, each folded as acc*85+digit modulo 2^32. Bytes
// outside the alphabet count as digit zero. The words channel delivers the
// word together with last_in_vector, which is set when the word completes a
// vector of the length held in the configuration register. The cfg channel
// writes that length; it is always ready and should only be written while
// the decoder is idle.
//
// Throughput is one character per clock while the receiver keeps up. The
// tenth character of a group passes through the input register and then
// the result register before it reaches the words channel. The single
// multiply by 85 plus the digit add is the longest path.
//
// Reset clears the character position, the accumulator, the word counter
// and both valid flags, and loads a vector length of 400. When the receiver
// stalls, the result register holds its word; characters that complete no
// word keep flowing, and the chars channel drops ready only when a further
// finished word would have nowhere to go.
module z85_double_word_decoder (
    input  logic         clk,
    input  logic         rst_n,
    z85dw_char_if.sink   chars,
    z85dw_word_if.source words,
    z85dw_cfg_if.sink    cfg
);
    import z85dw_pkg::*;

    digit_stage_t stage;
    logic         take;

    z85dw_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .take  (take),
        .stage (stage)
    );

    z85dw_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .words (words),
        .cfg   (cfg)
    );

endmodule
